@@ rtl/bem_pkg.sv @@
`timescale 1ns / 1ps
// bem_pkg: widths, codes and shared types for the border extension address map.
// No dependencies; imported by bem_axis, border_extension_address_map, bem_checker and testbench.
package bem_pkg;

  localparam int COORD_W   = 17;  // signed input coordinate
  localparam int DIM_W     = 13;  // width / height register
  localparam int POS_W     = 12;  // mapped column / row
  localparam int ADDR_W    = 24;
  localparam int MODE_W    = 3;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MAX_DIM   = 4096;

  // remainder datapath: divisor is n or 2n, dividend |c| padded to a multiple of steps
  localparam int DIV_W          = DIM_W + 1;
  localparam int DIV_STEPS      = 3;
  localparam int DIV_STGS       = (COORD_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NUM_W          = DIV_STGS * DIV_STEPS;
  localparam int AXIS_LAT       = DIV_STGS + 2;

  localparam logic [MODE_W-1:0] MODE_UNDEF    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FILL     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLAMP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIRROR   = 3'd4;

  localparam logic [ST_W-1:0] ST_INTERIOR = 2'd0;
  localparam logic [ST_W-1:0] ST_MAPPED   = 2'd1;
  localparam logic [ST_W-1:0] ST_FILL     = 2'd2;
  localparam logic [ST_W-1:0] ST_UNDEF    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

  // per-axis mapping control, derived from the mode register
  typedef struct packed {
    logic clamp;
    logic mirror;
  } bem_ctl_t;

endpackage

@@ rtl/bem_axis.sv @@
`timescale 1ns / 1ps
// bem_axis: pipelined map of one signed coordinate into [0, n) for clamp,
// periodic and mirror modes. Depends on bem_pkg.
module bem_axis (
  input  logic                                 clk,
  input  logic signed [bem_pkg::COORD_W-1:0]   coord,
  input  logic        [bem_pkg::DIM_W-1:0]     dim,
  input  bem_pkg::bem_ctl_t                    ctl,
  output logic        [bem_pkg::POS_W-1:0]     pos,
  output logic                                 in_image
);
  import bem_pkg::*;

  logic [DIV_W-1:0]   div;
  logic [COORD_W-1:0] mag;
  logic               in_a;
  logic [POS_W-1:0]   clamp_a;

  logic [NUM_W-1:0]   num_r    [DIV_STGS+1];
  logic [DIV_W-1:0]   rem_r    [DIV_STGS+1];
  logic               neg_r    [DIV_STGS+1];
  logic               in_r     [DIV_STGS+1];
  logic [POS_W-1:0]   clamp_r  [DIV_STGS+1];
  logic [NUM_W-1:0]   num_nxt  [DIV_STGS];
  logic [DIV_W-1:0]   rem_nxt  [DIV_STGS];

  logic [DIV_W-1:0]   fold;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_nxt;
  logic               inside_r;

  // the user must keep the divisor stable while items are in flight; the block does not enforce it
  assign div = ctl.mirror ? {dim, 1'b0} : {1'b0, dim};

  assign mag     = coord[COORD_W-1] ? (~unsigned'(coord) + COORD_W'(1)) : unsigned'(coord);
  assign in_a    = !coord[COORD_W-1] && (mag < {{(COORD_W-DIM_W){1'b0}}, dim});
  assign clamp_a = coord[COORD_W-1] ? '0 :
                   in_a ? mag[POS_W-1:0] : POS_W'(dim - DIM_W'(1));

  // restoring remainder, DIV_STEPS bits per stage
  always_comb begin
    logic [DIV_W-1:0] rem_t;
    logic [NUM_W-1:0] num_t;
    for (int s = 0; s < DIV_STGS; s++) begin
      rem_t = rem_r[s];
      num_t = num_r[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        rem_t = {rem_t[DIV_W-2:0], num_t[NUM_W-1]};
        num_t = {num_t[NUM_W-2:0], 1'b0};
        if (rem_t >= div) begin
          rem_t = rem_t - div;
        end
      end
      rem_nxt[s] = rem_t;
      num_nxt[s] = num_t;
    end
  end

  always_ff @(posedge clk) begin
    num_r[0]   <= {{(NUM_W-COORD_W){1'b0}}, mag};
    rem_r[0]   <= '0;
    neg_r[0]   <= coord[COORD_W-1];
    in_r[0]    <= in_a;
    clamp_r[0] <= clamp_a;
    for (int s = 0; s < DIV_STGS; s++) begin
      num_r[s+1]   <= num_nxt[s];
      rem_r[s+1]   <= rem_nxt[s];
      neg_r[s+1]   <= neg_r[s];
      in_r[s+1]    <= in_r[s];
      clamp_r[s+1] <= clamp_r[s];
    end
  end

  // floor correction for negative input, then fold the upper half for mirror
  always_comb begin
    fold = rem_r[DIV_STGS];
    if (neg_r[DIV_STGS] && (fold != '0)) begin
      fold = div - fold;
    end
    if (ctl.mirror && (fold >= {1'b0, dim})) begin
      fold = div - DIV_W'(1) - fold;
    end
    pos_nxt = (ctl.clamp || in_r[DIV_STGS]) ? clamp_r[DIV_STGS] : fold[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    inside_r <= in_r[DIV_STGS];
  end

  assign pos      = pos_r;
  assign in_image = inside_r;

endmodule

@@ rtl/border_extension_address_map.sv @@
`timescale 1ns / 1ps
// border_extension_address_map: top level, config registers, status and address stages.
// Depends on bem_pkg and bem_axis.
//
//  channel   ports                                          handshake
//  --------  ---------------------------------------------  -----------------------------
//  input     in_col_in, in_row_in                           start & !busy
//  result    out_col_out, out_row_out, out_address,         out_strobe, one cycle,
//            out_status                                     no backpressure
//  config    cfg_index, cfg_data                            cfg_valid & cfg_ready
//
// One coordinate pair per cycle, every cycle; busy is never raised.
// The result strobe follows the start transfer through the per-axis remainder
// pipeline, then the status, multiply and add stages.
// Reset (synchronous, rst_n low) clears the valid chain and sets width and
// height to 1, mode to undefined. The receiver cannot stall, so the pipeline
// simply advances every clock; config writes are expected only while empty.
module border_extension_address_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [bem_pkg::COORD_W-1:0]  in_col_in,
  input  logic signed [bem_pkg::COORD_W-1:0]  in_row_in,
  output logic                                out_strobe,
  output logic        [bem_pkg::POS_W-1:0]    out_col_out,
  output logic        [bem_pkg::POS_W-1:0]    out_row_out,
  output logic        [bem_pkg::ADDR_W-1:0]   out_address,
  output logic        [bem_pkg::ST_W-1:0]     out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [bem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [bem_pkg::DIM_W-1:0]    cfg_data
);
  import bem_pkg::*;

  localparam int TOTAL_LAT = AXIS_LAT + 3;

  // config registers
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [MODE_W-1:0] mode_r;
  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  bem_ctl_t          ctl;
  logic              accept;

  // pipeline
  logic [AXIS_LAT-1:0] vld_r;
  logic [POS_W-1:0]    col_pos;
  logic [POS_W-1:0]    row_pos;
  logic                col_in_img;
  logic                row_in_img;

  logic                stat_vld_r;
  logic [POS_W-1:0]    stat_col_r, stat_col_nxt;
  logic [POS_W-1:0]    stat_row_r, stat_row_nxt;
  logic [ST_W-1:0]     stat_st_r,  stat_st_nxt;

  logic                mul_vld_r;
  logic [POS_W-1:0]    mul_col_r;
  logic [POS_W-1:0]    mul_row_r;
  logic [ST_W-1:0]     mul_st_r;
  logic [ADDR_W-1:0]   mul_prod_r;

  logic                out_strobe_r;
  logic [POS_W-1:0]    out_col_r;
  logic [POS_W-1:0]    out_row_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [ST_W-1:0]     out_st_r;

  assign busy      = 1'b0;   // full rate, nothing to hold off
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      mode_r   <= MODE_UNDEF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_MODE:   mode_r   <= cfg_data[MODE_W-1:0];
        default:    ;  // unmapped index, dropped
      endcase
    end
  end

  // zero size acts as one, oversize saturates at MAX_DIM
  always_comb begin
    w_eff = (width_r == '0) ? DIM_W'(1) :
            (width_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : width_r;
    h_eff = (height_r == '0) ? DIM_W'(1) :
            (height_r > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_r;
    ctl.clamp  = (mode_r == MODE_CLAMP);
    ctl.mirror = (mode_r == MODE_MIRROR);
  end

  // valid chain matches the axis pipeline depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[AXIS_LAT-2:0], accept};
    end
  end

  bem_axis u_col (
    .clk      (clk),
    .coord    (in_col_in),
    .dim      (w_eff),
    .ctl      (ctl),
    .pos      (col_pos),
    .in_image (col_in_img)
  );

  bem_axis u_row (
    .clk      (clk),
    .coord    (in_row_in),
    .dim      (h_eff),
    .ctl      (ctl),
    .pos      (row_pos),
    .in_image (row_in_img)
  );

  // status stage: interior wins over any mode, fill/undefined zero the position
  always_comb begin
    stat_col_nxt = col_pos;
    stat_row_nxt = row_pos;
    if (col_in_img && row_in_img) begin
      stat_st_nxt = ST_INTERIOR;
    end else begin
      case (mode_r) inside
        MODE_FILL: begin
          stat_st_nxt  = ST_FILL;
          stat_col_nxt = '0;
          stat_row_nxt = '0;
        end
        MODE_CLAMP, MODE_PERIODIC, MODE_MIRROR: begin
          stat_st_nxt = ST_MAPPED;
        end
        default: begin
          stat_st_nxt  = ST_UNDEF;
          stat_col_nxt = '0;
          stat_row_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_vld_r   <= 1'b0;
      mul_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      stat_vld_r   <= vld_r[AXIS_LAT-1];
      mul_vld_r    <= stat_vld_r;
      out_strobe_r <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    stat_col_r <= stat_col_nxt;
    stat_row_r <= stat_row_nxt;
    stat_st_r  <= stat_st_nxt;
    // row times width, 12x13 multiply, low bits kept
    mul_prod_r <= ADDR_W'(stat_row_r * w_eff);
    mul_col_r  <= stat_col_r;
    mul_row_r  <= stat_row_r;
    mul_st_r   <= stat_st_r;
    out_addr_r <= mul_prod_r + {{(ADDR_W-POS_W){1'b0}}, mul_col_r};
    out_col_r  <= mul_col_r;
    out_row_r  <= mul_row_r;
    out_st_r   <= mul_st_r;
  end

  assign out_strobe  = out_strobe_r;
  assign out_col_out = out_col_r;
  assign out_row_out = out_row_r;
  assign out_address = out_addr_r;
  assign out_status  = out_st_r;

  // every transfer gives exactly one result after a fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##TOTAL_LAT out_strobe)
    else $error("result missing after input transfer");

  a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, TOTAL_LAT))
    else $error("result without input transfer");

  a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_FILL || out_status == ST_UNDEF)) |->
      (out_col_out == '0 && out_row_out == '0 && out_address == '0))
    else $error("fill/undefined result carries a position");

  a_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({1'b0, out_col_out} < w_eff && {1'b0, out_row_out} < h_eff))
    else $error("mapped position outside image");

endmodule

@@ tb/sv/bem_checker.sv @@
`timescale 1ns / 1ps
// bem_checker: predicts the mapped column, row, address and status of every
// coordinate transfer and compares them with the result strobes.
// Depends on bem_pkg; instantiated beside the block by testbench.
module bem_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [bem_pkg::COORD_W-1:0]   in_col_in,
  input  logic signed [bem_pkg::COORD_W-1:0]   in_row_in,
  input  logic                                 out_strobe,
  input  logic        [bem_pkg::POS_W-1:0]     out_col_out,
  input  logic        [bem_pkg::POS_W-1:0]     out_row_out,
  input  logic        [bem_pkg::ADDR_W-1:0]    out_address,
  input  logic        [bem_pkg::ST_W-1:0]      out_status,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic        [bem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [bem_pkg::DIM_W-1:0]     cfg_data,
  output int                                   errors,
  output int                                   pending
);
  import bem_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
    logic [ST_W-1:0]   st;
  } pixel_ref_t;

  pixel_ref_t         mapped_q[$];
  pixel_ref_t         head;
  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [MODE_W-1:0]  mode_reg;

  // zero acts as one, oversize saturates
  function automatic int usable_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int fold_coord(int c, int n, logic [MODE_W-1:0] mode);
    int m;
    case (mode)
      MODE_CLAMP: begin
        if (c < 0) return 0;
        if (c > n - 1) return n - 1;
        return c;
      end
      MODE_PERIODIC: begin
        m = c % n;
        if (m < 0) m += n;
        return m;
      end
      default: begin
        // mirror: true floor modulo over 2n, then reflect the upper half
        m = c % (2 * n);
        if (m < 0) m += 2 * n;
        if (m >= n) m = 2 * n - 1 - m;
        return m;
      end
    endcase
  endfunction

  function automatic pixel_ref_t map_pixel(logic signed [COORD_W-1:0] col,
                                           logic signed [COORD_W-1:0] row);
    int c, r, w, h, mc, mr;
    pixel_ref_t p;
    c  = col;
    r  = row;
    w  = usable_dim(width_reg);
    h  = usable_dim(height_reg);
    mc = 0;
    mr = 0;
    if (c >= 0 && c < w && r >= 0 && r < h) begin
      mc   = c;
      mr   = r;
      p.st = ST_INTERIOR;
    end else if (mode_reg == MODE_FILL) begin
      p.st = ST_FILL;
    end else if (mode_reg == MODE_CLAMP || mode_reg == MODE_PERIODIC ||
                 mode_reg == MODE_MIRROR) begin
      mc   = fold_coord(c, w, mode_reg);
      mr   = fold_coord(r, h, mode_reg);
      p.st = ST_MAPPED;
    end else begin
      p.st = ST_UNDEF;
    end
    p.col  = POS_W'(mc);
    p.row  = POS_W'(mr);
    p.addr = ADDR_W'(mc + mr * w);
    return p;
  endfunction

  // errors and pending are two-state and start at zero
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  <= 13'd1;
      height_reg <= 13'd1;
      mode_reg   <= MODE_UNDEF;
      mapped_q.delete();
    end else begin
      if (out_strobe) begin
        if (mapped_q.size() == 0) begin
          $error("result with no coordinate outstanding");
          errors++;
        end else begin
          head = mapped_q.pop_front();
          if (out_col_out !== head.col) begin
            $error("col_out: expected %0d, got %0d", head.col, out_col_out);
            errors++;
          end
          if (out_row_out !== head.row) begin
            $error("row_out: expected %0d, got %0d", head.row, out_row_out);
            errors++;
          end
          if (out_address !== head.addr) begin
            $error("address: expected %0d, got %0d", head.addr, out_address);
            errors++;
          end
          if (out_status !== head.st) begin
            $error("status: expected %0d, got %0d", head.st, out_status);
            errors++;
          end
        end
      end
      if (start && !busy) mapped_q.push_back(map_pixel(in_col_in, in_row_in));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  width_reg  <= cfg_data;
          CFG_HEIGHT: height_reg <= cfg_data;
          CFG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
    end
    pending = mapped_q.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: stimulus, watchdog and verdict for border_extension_address_map.
// Depends on bem_pkg, the block and bem_checker.
module testbench;
  import bem_pkg::*;

  // stall watchdog: cycles with no transfer on any channel
  localparam int STALL_LIMIT = 2000;
  // settle time before a register write, a little over the input-to-result path of the block
  localparam int SETTLE      = 16;
  localparam int PHASES      = 30;
  // codes 5..7 are unused and must behave as undefined
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic signed [COORD_W-1:0]   in_col_in;
  logic signed [COORD_W-1:0]   in_row_in;
  logic                        out_strobe;
  logic        [POS_W-1:0]     out_col_out;
  logic        [POS_W-1:0]     out_row_out;
  logic        [ADDR_W-1:0]    out_address;
  logic        [ST_W-1:0]      out_status;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic        [CFG_IDX_W-1:0] cfg_index;
  logic        [DIM_W-1:0]     cfg_data;

  int chk_errors;
  int chk_pending;
  int stall_cycles;
  // effective image size as last programmed; steers the coordinate mix
  int cur_w;
  int cur_h;

  border_extension_address_map u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_col_in   (in_col_in),
    .in_row_in   (in_row_in),
    .out_strobe  (out_strobe),
    .out_col_out (out_col_out),
    .out_row_out (out_row_out),
    .out_address (out_address),
    .out_status  (out_status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  bem_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_col_in   (in_col_in),
    .in_row_in   (in_row_in),
    .out_strobe  (out_strobe),
    .out_col_out (out_col_out),
    .out_row_out (out_row_out),
    .out_address (out_address),
    .out_status  (out_status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (chk_errors),
    .pending     (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. Any coordinate, result or register transfer restarts the count;
  // the longest legal quiet stretch is a sender gap or the pre-write settle.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int usable_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // One coordinate transfer. start is raised at the falling edge and left high
  // so back-to-back calls form a burst; pause() drops it.
  task automatic send_coord(input int c, input int r);
    @(negedge clk);
    start     <= 1'b1;
    in_col_in <= COORD_W'(c);
    in_row_in <= COORD_W'(r);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Registers only change with the pipeline empty: stop the sender, wait out
  // every outstanding result, then give the datapath the SETTLE time as well.
  task automatic drain();
    pause(1);
    while (chk_pending != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mode_word is the full 13-bit write; only the low 3 bits land in the register
  task automatic set_config(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [DIM_W-1:0] mode_word);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_MODE, mode_word);
    cur_w = usable_dim(w);
    cur_h = usable_dim(h);
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'(MAX_DIM);
      3:       return 13'($urandom_range(8191, MAX_DIM + 1));
      4:       return 13'($urandom_range(MAX_DIM - 1, 2));
      5:       return 13'($urandom_range(300, 17));
      default: return 13'($urandom_range(16, 1));
    endcase
  endfunction

  // Mix of interior points, points a few image sizes out (where folding does
  // its work), exact multiples of the size and of twice the size, field
  // extremes, and raw random words that toggle every coordinate bit.
  function automatic int pick_coord(int n);
    int v;
    case ($urandom_range(9))
      0:       v = int'($urandom_range(n - 1));
      1, 2, 3: v = int'($urandom_range(6 * n)) - 3 * n;
      4:       v = -(2 * n) * int'($urandom_range(65536 / (2 * n)));
      5:       v = n * int'($urandom_range(65535 / n)) - int'($urandom_range(1));
      6: begin
        case ($urandom_range(5))
          0:       v = -65536;
          1:       v = 65535;
          2:       v = -1;
          3:       v = n;
          4:       v = -n;
          default: v = n - 1;
        endcase
      end
      default: v = int'($urandom_range(131071)) - 65536;
    endcase
    if (v < -65536) v = -65536;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  initial begin
    int          items;
    int          burst;
    int          gap_max;
    logic [2:0]  mode_pick;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_col_in = '0;
    in_row_in = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data  = '0;
    cur_w = 1;
    cur_h = 1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    // reset configuration: 1x1 image, exterior undefined
    send_coord(0, 0);
    send_coord(-65536, -65536);
    send_coord(65535, 65535);
    send_coord(1, 0);

    // full-size mirror: corner interior, negative exact multiple of 2n,
    // just outside on both sides, far field extremes
    set_config(13'(MAX_DIM), 13'(MAX_DIM), 13'(MODE_MIRROR));
    send_coord(4095, 4095);
    send_coord(-8192, -65536);
    send_coord(-1, -1);
    send_coord(4096, 8191);
    send_coord(-65536, 65535);

    set_config(13'd7, 13'd5, 13'(MODE_CLAMP));
    send_coord(-3, 2);
    send_coord(10, -1);
    send_coord(65535, -65536);

    set_config(13'd7, 13'd5, 13'(MODE_PERIODIC));
    send_coord(-7, -5);
    send_coord(-1, 12);
    send_coord(65535, -65536);

    set_config(13'd7, 13'd5, 13'(MODE_FILL));
    send_coord(-1, 0);
    send_coord(3, 3);

    // zero width acts as one, oversize height saturates, spare mode with the
    // upper data bits set still reads as undefined
    set_config(13'd0, 13'h1FFF, {10'h3FF, MODE_SPARE_HI});
    send_coord(0, 0);
    send_coord(0, 4095);
    send_coord(1, 0);
    send_coord(0, 4096);

    set_config(13'd3, 13'd2, 13'(MODE_SPARE_LO));
    send_coord(5, 1);
    send_coord(2, 1);

    // ---- random phases ----
    // Mostly the folding modes, since those carry the arithmetic. Some phases
    // run without gaps so that full-rate streams are covered too.
    for (int ph = 0; ph < PHASES; ph++) begin
      if ($urandom_range(9) < 3) mode_pick = 3'($urandom_range(7));
      else mode_pick = 3'($urandom_range(MODE_MIRROR, MODE_CLAMP));
      set_config(pick_dim(), pick_dim(), {10'($urandom), mode_pick});
      items   = $urandom_range(60, 30);
      gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
      while (items > 0) begin
        burst = $urandom_range(16, 1);
        for (int i = 0; i < burst && items > 0; i++) begin
          send_coord(pick_coord(cur_w), pick_coord(cur_h));
          items--;
        end
        pause($urandom_range(gap_max));
      end
    end

    // ---- wrap up ----
    pause(1);
    while (chk_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (chk_pending != 0) $error("%0d results never arrived", chk_pending);
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
